// ===== hdl/awc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awc_pkg
// Shared constants, types and state codes of the anti-replay window check.
// ----------------------------------------------------------------------------
package awc_pkg;

   // Sizing of the window store.
   localparam int SLOT_COUNT   = 8;
   localparam int STREAM_COUNT = 4;
   localparam int WINDOW_BITS  = 256;

   // Fixed field widths of a request and a response.
   localparam int SLOT_W   = 3;
   localparam int STREAM_W = 2;
   localparam int SEQ_W    = 64;

   // Derived sizes.
   localparam int WIN_COUNT = SLOT_COUNT * STREAM_COUNT;
   localparam int WIN_W     = (WIN_COUNT > 1) ? $clog2(WIN_COUNT) : 1;
   localparam int IDX_W     = $clog2(WINDOW_BITS);

   typedef logic [WINDOW_BITS-1:0] awc_row_type;
   typedef logic [SEQ_W-1:0]       awc_seq_type;
   typedef logic [WIN_W-1:0]       awc_widx_type;

   // Contents of one window.
   typedef struct packed {
      awc_seq_type highest;
      awc_row_type bitmap;
   } awc_win_type;

   // Read port request of the window store.
   typedef struct packed {
      logic         en;
      awc_widx_type win;
   } awc_rd_type;

   // Write port request of the window store.
   typedef struct packed {
      logic         en;
      awc_widx_type win;
      awc_win_type  data;
   } awc_wr_type;

   // Outcome of one window check.
   typedef struct packed {
      logic        write;
      logic        accept;
      awc_win_type win;
   } awc_upd_type;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } awc_state_type;

endpackage
`default_nettype wire

// ===== hdl/awc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awc_req_if / awc_rsp_if
// Valid/ready channels that carry requests into and responses out of the
// anti-replay window check.
// ----------------------------------------------------------------------------
interface awc_req_if;
   logic                           valid;
   logic                           ready;
   logic [awc_pkg::SLOT_W-1:0]     peer_slot;
   logic [awc_pkg::STREAM_W-1:0]   stream_index;
   logic [awc_pkg::SEQ_W-1:0]      sequence_req;

   modport source (output valid, peer_slot, stream_index, sequence_req,
                   input ready);
   modport sink   (input valid, peer_slot, stream_index, sequence_req,
                   output ready);
endinterface

interface awc_rsp_if;
   logic valid;
   logic ready;
   logic accept;

   modport source (output valid, accept, input ready);
   modport sink   (input valid, accept, output ready);
endinterface
`default_nettype wire

// ===== hdl/awc_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awc_store
// Window memories: highest sequence and seen bitmap per window, with a
// registered read and a per-window valid flag that stands for reset.
// ----------------------------------------------------------------------------
module awc_store (
   input  logic                 clock,
   input  logic                 reset,
   input  awc_pkg::awc_rd_type  rd,
   input  awc_pkg::awc_wr_type  wr,
   output awc_pkg::awc_win_type rd_data
);

   awc_pkg::awc_seq_type highest_mem [awc_pkg::WIN_COUNT];
   awc_pkg::awc_row_type bitmap_mem  [awc_pkg::WIN_COUNT];

   logic [awc_pkg::WIN_COUNT-1:0] valid_ff;
   logic                          rd_valid_ff;
   awc_pkg::awc_seq_type          rd_highest_ff;
   awc_pkg::awc_row_type          rd_bitmap_ff;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         highest_mem[wr.win] <= wr.data.highest;
         bitmap_mem[wr.win]  <= wr.data.bitmap;
      end
      if (rd.en) begin
         rd_highest_ff <= highest_mem[rd.win];
         rd_bitmap_ff  <= bitmap_mem[rd.win];
      end
   end

   // A window counts as empty until its first write after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.win] <= 1'b1;
         end
         if (rd.en) begin
            rd_valid_ff <= valid_ff[rd.win];
         end
      end
   end

   // An empty window reads as all zero.
   always_comb begin
      rd_data.highest = rd_valid_ff ? rd_highest_ff : '0;
      rd_data.bitmap  = rd_valid_ff ? rd_bitmap_ff  : '0;
   end

endmodule
`default_nettype wire

// ===== hdl/awc_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awc_update
// Checks one sequence number against its window and forms the new window.
// ----------------------------------------------------------------------------
module awc_update (
   input  logic                  in_range,
   input  awc_pkg::awc_seq_type  sequence_req,
   input  awc_pkg::awc_win_type  cur,
   output awc_pkg::awc_upd_type  upd
);

   logic [awc_pkg::SEQ_W:0]     ahead;
   awc_pkg::awc_seq_type        behind;
   logic                        newer;
   logic [awc_pkg::IDX_W-1:0]   shift_amt;
   logic [awc_pkg::IDX_W-1:0]   bit_idx;

   always_comb begin
      // Distance in both directions from the highest sequence seen.
      ahead     = {1'b0, sequence_req} - {1'b0, cur.highest};
      behind    = cur.highest - sequence_req;
      newer     = !ahead[awc_pkg::SEQ_W] && (ahead[awc_pkg::SEQ_W-1:0] != '0);
      shift_amt = ahead[awc_pkg::IDX_W-1:0];
      bit_idx   = behind[awc_pkg::IDX_W-1:0];

      upd.write  = 1'b0;
      upd.accept = 1'b0;
      upd.win    = cur;

      // Sequence zero and unknown windows are rejected without a change.
      if (in_range && (sequence_req != '0)) begin
         if (newer) begin
            // Slide the window forward and mark the new highest.
            upd.write       = 1'b1;
            upd.accept      = 1'b1;
            upd.win.highest = sequence_req;
            if (ahead[awc_pkg::SEQ_W-1:0] >= awc_pkg::SEQ_W'(awc_pkg::WINDOW_BITS)) begin
               upd.win.bitmap = awc_pkg::awc_row_type'(1);
            end else begin
               upd.win.bitmap = (cur.bitmap << shift_amt) | awc_pkg::awc_row_type'(1);
            end
         end else if (behind < awc_pkg::SEQ_W'(awc_pkg::WINDOW_BITS)) begin
            // Inside the window: accept only if not yet marked.
            if (!cur.bitmap[bit_idx]) begin
               upd.write      = 1'b1;
               upd.accept     = 1'b1;
               upd.win.bitmap = cur.bitmap | (awc_pkg::awc_row_type'(1) << bit_idx);
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== hdl/anti_replay_window_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anti_replay_window_check
// Per-slot, per-stream sliding-window replay filter for received packets.
// ----------------------------------------------------------------------------
// Each request names a sender slot, a stream and a 64-bit sequence number;
// the response says whether the packet is fresh (1) or replayed, too old or
// zero (0), and a fresh packet is marked in its window. A request passes
// through two steps: the synchronous read of the window memories, then the
// check, update and write-back of the window in ST_EXEC, so at most one
// request is in work and a new one is taken only once ST_EXEC is left. A
// response held back by the sink keeps the request in its update cycle; the
// next request can still be taken while a finished response waits. After
// reset every window reads as empty through per-window valid flags, so no
// clearing pass is needed and requests are taken at once.
// ----------------------------------------------------------------------------
module anti_replay_window_check (
   input  logic        clock,
   input  logic        reset,
   awc_req_if.sink     req_chan,
   awc_rsp_if.source   rsp_chan
);

   awc_pkg::awc_state_type state_ff, state_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept_ff, accept_in;
   awc_pkg::awc_seq_type  seq_ff;
   logic                  in_range_ff;
   awc_pkg::awc_widx_type win_ff;

   logic                  req_fire;
   logic                  rsp_free;
   logic                  req_in_range;
   awc_pkg::awc_widx_type req_win;

   awc_pkg::awc_rd_type   rd;
   awc_pkg::awc_wr_type   wr;
   awc_pkg::awc_win_type  cur;
   awc_pkg::awc_upd_type  upd;

   // Window index and range check of an incoming request.
   always_comb begin
      req_in_range = (32'(req_chan.peer_slot) < awc_pkg::SLOT_COUNT) &&
                     (32'(req_chan.stream_index) < awc_pkg::STREAM_COUNT);
      req_win      = awc_pkg::WIN_W'(32'(req_chan.peer_slot) * awc_pkg::STREAM_COUNT +
                                     32'(req_chan.stream_index));
   end

   // Window memories.
   awc_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd      (rd),
      .wr      (wr),
      .rd_data (cur)
   );

   // Check and update logic.
   awc_update u_update (
      .in_range     (in_range_ff),
      .sequence_req (seq_ff),
      .cur          (cur),
      .upd          (upd)
   );

   // Sequencer: next state, handshakes and memory ports.
   always_comb begin
      req_chan.ready = (state_ff == awc_pkg::ST_IDLE) && !reset;
      req_fire       = req_chan.valid && req_chan.ready;
      rsp_free       = !rsp_valid_ff || rsp_chan.ready;

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      accept_in    = accept_ff;

      rd.en  = req_fire;
      rd.win = req_win;

      wr.en   = 1'b0;
      wr.win  = win_ff;
      wr.data = upd.win;

      case (state_ff)
         awc_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = awc_pkg::ST_EXEC;
            end
         end
         awc_pkg::ST_EXEC: begin
            if (rsp_free) begin
               wr.en        = upd.write;
               rsp_valid_in = 1'b1;
               accept_in    = upd.accept;
               state_in     = awc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = awc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= awc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      accept_ff <= accept_in;
      if (req_fire) begin
         seq_ff      <= req_chan.sequence_req;
         in_range_ff <= req_in_range;
         win_ff      <= req_win;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.accept = accept_ff;

endmodule
`default_nettype wire

// ===== hdl/awc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awc_checker
// Port-level checks of the anti-replay window check, bound to the top level.
// ----------------------------------------------------------------------------
module awc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [awc_pkg::SEQ_W-1:0]  req_sequence,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_accept
);

   // A pending response stays until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // A stalled response keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_accept))
      else $error("stalled response changed");

   // Only one request is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // With the output free, every request taken gets a response.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |-> ##2 rsp_valid)
      else $error("response missing after request");

   // Sequence zero is always rejected.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid && (req_sequence == '0)
      |-> ##2 (rsp_valid && !rsp_accept))
      else $error("sequence zero accepted");

endmodule

bind anti_replay_window_check awc_checker u_awc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_sequence (req_chan.sequence_req),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_accept   (rsp_chan.accept)
);
`default_nettype wire
